### hdl/upload_rate_window_meter_defines.svh
// Assertion macros used by the meter's top module.
`ifndef UPLOAD_RATE_WINDOW_METER_DEFINES_SVH
`define UPLOAD_RATE_WINDOW_METER_DEFINES_SVH
`ifndef SYNTH
`define URWM_ASSERT(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define URWM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define URWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define URWM_ASSERT(label, clk, rst_n, expr)
`define URWM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define URWM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/urwm_pkg.sv
package urwm_pkg;
  localparam int PENDING_DEPTH = 16;
  localparam int WINDOW_DEPTH  = 64;
  localparam int PPTR_W = $clog2(PENDING_DEPTH);
  localparam int PCNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int WPTR_W = $clog2(WINDOW_DEPTH);
  localparam int WCNT_W = $clog2(WINDOW_DEPTH + 1);
  // Total of all window records, each below 2^32.
  localparam int TOTAL_W = 32 + WCNT_W;

  localparam logic [15:0] WINDOW_MS_RESET = 16'd3000;
  localparam logic [9:0]  MS_PER_SEC      = 10'd1000;

  localparam logic [1:0] CMD_QUEUE  = 2'd0;
  localparam logic [1:0] CMD_SENT   = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] byte_count;
    logic        is_protocol;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [31:0] rate_bps;
    logic        dropped;
  } out_word_t;

  typedef struct packed {
    logic [31:0] size;
    logic        is_data;
    logic [31:0] start;
  } pend_rec_t;

  typedef struct packed {
    logic [31:0] size;
    logic [31:0] start;
    logic [31:0] duration;
  } win_rec_t;
endpackage

### hdl/urwm_div.sv
module urwm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [63:0] quotient
);
  logic [63:0] dvd_r;
  logic [31:0] rem_r;
  logic [31:0] dvs_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] sh;
  logic        fit;

  // One quotient bit per cycle, restoring form; quotient bits shift into dvd_r.
  assign sh  = {rem_r, dvd_r[63]};
  assign fit = sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fit ? 32'(sh - {1'b0, dvs_r}) : sh[31:0];
        dvd_r <= {dvd_r[62:0], fit};
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = dvd_r;
endmodule

### hdl/upload_rate_window_meter.sv
// One word in gives one word out. A sent command does one memory read and one
// evaluation per retired pending record. An update reads and evaluates each
// window record; for each record that is only partly inside the window it
// multiplies, then uses the shared divider, and the final rate division uses
// the same divider. The result register lets the next word enter while a
// result waits.
`include "upload_rate_window_meter_defines.svh"
module upload_rate_window_meter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  urwm_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output urwm_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import urwm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_P_RD, S_P_EV, S_W_RD, S_W_EV, S_W_ADD, S_W_DIV,
    S_R_MUL, S_R_START, S_R_DIV, S_DONE
  } state_t;

  state_t             state_r;
  logic [15:0]        win_r;
  logic [PCNT_W-1:0]  pcnt_r;
  logic [PPTR_W-1:0]  phead_r;
  logic [WCNT_W-1:0]  wcnt_r;
  logic [WCNT_W-1:0]  k_r;
  logic [WCNT_W-1:0]  kept_r;
  logic [31:0]        carry_r;
  logic [31:0]        rate_r;
  logic [31:0]        bytes_r;
  logic [31:0]        now_r;
  logic               drop_r;
  logic [TOTAL_W-1:0] total_r;
  logic [63:0]        prod_r;
  logic [31:0]        du_r;
  logic               out_valid_r;
  out_word_t          out_r;

  pend_rec_t pmem [PENDING_DEPTH];
  win_rec_t  wmem [WINDOW_DEPTH];
  pend_rec_t p_rd_r;
  win_rec_t  w_rd_r;

  logic              in_acc;
  logic              out_load;
  logic              p_we;
  logic [PPTR_W-1:0] p_waddr;
  logic              w_we;
  logic [WPTR_W-1:0] w_waddr;
  win_rec_t          w_wdata;
  logic [WPTR_W-1:0] w_raddr;

  logic [31:0] w32;
  logic [32:0] avail;
  logic [32:0] rest;
  logic        head_fits;
  logic [31:0] bytes_nxt;
  logic [31:0] w_end;
  logic        keep;
  logic        whole;
  logic [31:0] part;

  logic        div_start;
  logic [63:0] div_dvd;
  logic [31:0] div_dvs;
  logic        div_busy;
  logic        div_done;
  logic [63:0] div_q;

  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign w32      = (win_r == 16'd0) ? 32'd1 : {16'd0, win_r};

  // Sent-bytes retirement against the head record.
  assign avail     = {1'b0, bytes_r} + {1'b0, carry_r};
  assign head_fits = {1'b0, p_rd_r.size} <= avail;
  assign rest      = avail - {1'b0, p_rd_r.size};
  assign bytes_nxt = rest[32] ? 32'hFFFF_FFFF : rest[31:0];

  // Window record classification; all time arithmetic wraps.
  assign w_end = w_rd_r.start + w_rd_r.duration;
  assign keep  = (now_r - w_end) <= w32;
  assign whole = (now_r - w_rd_r.start) <= w32;
  assign part  = w_end - (now_r - w32);

  assign p_we    = in_acc && (in_data.cmd == CMD_QUEUE) &&
                   (pcnt_r < PCNT_W'(PENDING_DEPTH));
  assign p_waddr = PPTR_W'(phead_r + pcnt_r[PPTR_W-1:0]);

  always_comb begin
    w_we    = 1'b0;
    w_waddr = kept_r[WPTR_W-1:0];
    w_wdata = w_rd_r;
    if (state_r == S_P_EV && head_fits && p_rd_r.is_data &&
        wcnt_r < WCNT_W'(WINDOW_DEPTH)) begin
      w_we             = 1'b1;
      w_waddr          = wcnt_r[WPTR_W-1:0];
      w_wdata.size     = p_rd_r.size;
      w_wdata.start    = p_rd_r.start;
      w_wdata.duration = now_r - p_rd_r.start;
    end else if (state_r == S_W_EV && keep) begin
      w_we = 1'b1;
    end
  end

  assign w_raddr = k_r[WPTR_W-1:0];

  always_ff @(posedge clk) begin
    if (p_we) pmem[p_waddr] <= '{in_data.byte_count, !in_data.is_protocol, in_data.now_ms};
    p_rd_r <= pmem[phead_r];
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    w_rd_r <= wmem[w_raddr];
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = prod_r;
    div_dvs   = w32;
    if (state_r == S_W_ADD) begin
      div_start = 1'b1;
      div_dvd   = prod_r + {32'd0, du_r - 32'd1};
      div_dvs   = du_r;
    end else if (state_r == S_R_START) begin
      div_start = 1'b1;
    end
  end

  urwm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= WINDOW_MS_RESET;
      pcnt_r      <= '0;
      phead_r     <= '0;
      wcnt_r      <= '0;
      carry_r     <= '0;
      rate_r      <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      if (cfg_we) win_r <= cfg_wdata;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            bytes_r <= in_data.byte_count;
            now_r   <= in_data.now_ms;
            drop_r  <= (in_data.cmd == CMD_QUEUE) && !p_we;
            k_r     <= '0;
            kept_r  <= '0;
            total_r <= '0;
            if (p_we) pcnt_r <= pcnt_r + PCNT_W'(1);
            if (in_data.cmd == CMD_SENT && in_data.byte_count != 32'd0 && pcnt_r != '0)
              state_r <= S_P_RD;
            else if (in_data.cmd == CMD_UPDATE && wcnt_r != '0)
              state_r <= S_W_RD;
            else
              state_r <= S_DONE;
          end
        end
        S_P_RD: state_r <= S_P_EV;
        S_P_EV: begin
          if (head_fits) begin
            bytes_r <= bytes_nxt;
            carry_r <= '0;
            phead_r <= phead_r + PPTR_W'(1);
            pcnt_r  <= pcnt_r - PCNT_W'(1);
            if (p_rd_r.is_data) begin
              if (w_we) wcnt_r <= wcnt_r + WCNT_W'(1);
              else drop_r <= 1'b1;
            end
            state_r <= (bytes_nxt != 32'd0 && pcnt_r != PCNT_W'(1)) ? S_P_RD : S_DONE;
          end else begin
            carry_r <= avail[31:0];
            bytes_r <= '0;
            state_r <= S_DONE;
          end
        end
        S_W_RD: state_r <= S_W_EV;
        S_W_EV: begin
          k_r <= k_r + WCNT_W'(1);
          if (keep && !whole && w_rd_r.duration != 32'd0) begin
            prod_r  <= part * w_rd_r.size;
            du_r    <= w_rd_r.duration;
            state_r <= S_W_ADD;
          end else begin
            state_r <= (k_r + WCNT_W'(1) < wcnt_r) ? S_W_RD : S_R_MUL;
          end
          if (keep) begin
            kept_r <= kept_r + WCNT_W'(1);
            if (whole) total_r <= total_r + TOTAL_W'(w_rd_r.size);
          end
        end
        S_W_ADD: state_r <= S_W_DIV;
        S_W_DIV: begin
          if (div_done) begin
            total_r <= total_r + TOTAL_W'(div_q[31:0]);
            state_r <= (k_r < wcnt_r) ? S_W_RD : S_R_MUL;
          end
        end
        S_R_MUL: begin
          wcnt_r  <= kept_r;
          prod_r  <= 64'(total_r) * 64'(MS_PER_SEC);
          state_r <= S_R_START;
        end
        S_R_START: state_r <= S_R_DIV;
        S_R_DIV: begin
          if (div_done) begin
            rate_r  <= (div_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_q[31:0];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_r.rate_bps <= rate_r;
            out_r.dropped  <= drop_r;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `URWM_ASSERT(a_pcnt_max, clk, rst_n, pcnt_r <= PCNT_W'(PENDING_DEPTH))
  `URWM_ASSERT(a_wcnt_max, clk, rst_n, wcnt_r <= WCNT_W'(WINDOW_DEPTH))
  `URWM_ASSERT_IMPL(a_div_idle, clk, rst_n, state_r == S_IDLE, !div_busy)
  `URWM_ASSERT_IMPL(a_kept_le_k, clk, rst_n, state_r == S_W_EV, kept_r <= k_r)
  `URWM_ASSERT_NEXT(a_sent_pop, clk, rst_n, state_r == S_P_EV && head_fits,
                    pcnt_r == $past(pcnt_r) - PCNT_W'(1))
endmodule

### tb/sv/tb_upload_rate_window_meter.sv
module tb_upload_rate_window_meter;
  import urwm_pkg::*;

  localparam int PEND_MAX = 16;
  localparam int WIN_MAX  = 64;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  upload_rate_window_meter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow state of the meter.
  logic [15:0] win_len;
  logic [31:0] q_size [PEND_MAX];
  logic        q_data [PEND_MAX];
  logic [31:0] q_start [PEND_MAX];
  int          q_cnt;
  logic [31:0] w_size [WIN_MAX];
  logic [31:0] w_start [WIN_MAX];
  logic [31:0] w_dur [WIN_MAX];
  int          w_cnt;
  logic [31:0] carry;
  logic [31:0] rate;

  out_word_t expected_words[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_out = 1'b0;
  int sent_words = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic void meter_reset();
    win_len = WINDOW_MS_RESET;
    q_cnt = 0;
    w_cnt = 0;
    carry = '0;
    rate = '0;
  endfunction

  function automatic void refresh_rate(input logic [31:0] now);
    logic [31:0] w, st, du, fin, part;
    logic [95:0] total, r;
    logic [63:0] prod;
    int kept;
    w = (win_len == 0) ? 32'd1 : {16'd0, win_len};
    total = '0;
    kept = 0;
    if (w_cnt == 0) return;
    for (int k = 0; k < w_cnt; k++) begin
      st = w_start[k];
      du = w_dur[k];
      fin = st + du;
      if (now - fin > w) continue;
      if (now - st <= w) begin
        total += w_size[k];
      end else if (du != 0) begin
        part = fin - (now - w);
        prod = {32'd0, part} * {32'd0, w_size[k]};
        total += (prod + {32'd0, du - 32'd1}) / {32'd0, du};
      end
      w_size[kept] = w_size[k];
      w_start[kept] = st;
      w_dur[kept] = du;
      kept++;
    end
    w_cnt = kept;
    r = (total * 1000) / w;
    rate = (r > 96'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  function automatic out_word_t meter_step(input in_word_t word);
    out_word_t res;
    logic [31:0] bytes, sz, st;
    logic [32:0] avail;
    logic dat;
    res.dropped = 1'b0;
    bytes = word.byte_count;
    case (word.cmd)
      CMD_QUEUE: begin
        if (q_cnt < PEND_MAX) begin
          q_size[q_cnt] = word.byte_count;
          q_data[q_cnt] = !word.is_protocol;
          q_start[q_cnt] = word.now_ms;
          q_cnt++;
        end else begin
          res.dropped = 1'b1;
        end
      end
      CMD_SENT: begin
        while (bytes != 0 && q_cnt > 0) begin
          avail = {1'b0, bytes} + {1'b0, carry};
          if ({1'b0, q_size[0]} <= avail) begin
            avail = avail - {1'b0, q_size[0]};
            bytes = avail[32] ? 32'hFFFF_FFFF : avail[31:0];
            carry = '0;
            sz = q_size[0];
            dat = q_data[0];
            st = q_start[0];
            for (int k = 1; k < q_cnt; k++) begin
              q_size[k-1] = q_size[k];
              q_data[k-1] = q_data[k];
              q_start[k-1] = q_start[k];
            end
            q_cnt--;
            if (dat) begin
              if (w_cnt < WIN_MAX) begin
                w_size[w_cnt] = sz;
                w_start[w_cnt] = st;
                w_dur[w_cnt] = word.now_ms - st;
                w_cnt++;
              end else begin
                res.dropped = 1'b1;
              end
            end
          end else begin
            carry = avail[31:0];
            bytes = '0;
          end
        end
      end
      CMD_UPDATE: refresh_rate(word.now_ms);
      default: ;
    endcase
    res.rate_bps = rate;
    return res;
  endfunction

  // Sender side.
  task automatic send_word(input in_word_t word);
    if (!quiet && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.push_back(meter_step(word));
    sent_words++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (5000) @(posedge clk);
  endtask

  task automatic set_window(input logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_len = val;
  endtask

  function automatic in_word_t make_word(input logic [1:0] c, input logic [31:0] b,
                                         input logic p, input logic [31:0] t);
    in_word_t word;
    word.cmd = c;
    word.byte_count = b;
    word.is_protocol = p;
    word.now_ms = t;
    return word;
  endfunction

  // Directed rows: the expected value is given where it is plain, else -1.
  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] bytes;
    logic        proto;
    logic [31:0] now;
    longint      want_rate;
    int          want_drop;
  } step_row_t;

  step_row_t rows[] = '{
    '{CMD_UPDATE, 32'd0, 1'b0, 32'd100, 0, 0},
    '{CMD_NONE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 0, 0},
    '{CMD_SENT, 32'd500, 1'b0, 32'd110, 0, 0},
    '{CMD_QUEUE, 32'd1000, 1'b0, 32'd120, 0, 0},
    '{CMD_QUEUE, 32'd300, 1'b1, 32'd125, 0, 0},
    '{CMD_SENT, 32'd600, 1'b0, 32'd130, 0, 0},
    '{CMD_SENT, 32'd0, 1'b0, 32'd140, 0, 0},
    '{CMD_SENT, 32'd700, 1'b0, 32'd900, -1, 0},
    '{CMD_UPDATE, 32'd0, 1'b0, 32'd1000, -1, 0},
    '{CMD_QUEUE, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFF0, -1, 0},
    '{CMD_SENT, 32'hFFFF_FFFF, 1'b0, 32'd20, -1, 0},
    '{CMD_UPDATE, 32'd0, 1'b0, 32'd30, -1, 0},
    '{CMD_QUEUE, 32'd50, 1'b0, 32'd40, -1, 0},
    '{CMD_SENT, 32'd50, 1'b0, 32'd40, -1, 0},
    '{CMD_UPDATE, 32'd0, 1'b0, 32'd1500, -1, 0},
    '{CMD_UPDATE, 32'd0, 1'b0, 32'd3100, -1, 0},
    '{CMD_UPDATE, 32'd0, 1'b0, 32'd9000, 0, 0},
    '{CMD_UPDATE, 32'd0, 1'b0, 32'd9100, 0, 0},
    '{CMD_NONE, 32'd0, 1'b0, 32'd0, 0, 0}
  };

  // Result checker.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report("unexpected word", out_data.rate_bps, '0);
      end else begin
        want = expected_words.pop_front();
        if (out_data.rate_bps !== want.rate_bps)
          report("rate_bps", out_data.rate_bps, want.rate_bps);
        if (out_data.dropped !== want.dropped)
          report("dropped", {31'd0, out_data.dropped}, {31'd0, want.dropped});
      end
    end
  end

  // Receiver stalls.
  always @(posedge clk) begin
    if (hold_out) out_stall <= 1'b1;
    else if (quiet) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 16);
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0] clock_ms;
    int n, pick;
    out_word_t want;
    meter_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      want = meter_step(make_word(rows[i].cmd, rows[i].bytes, rows[i].proto, rows[i].now));
      if (rows[i].want_rate >= 0 && want.rate_bps !== rows[i].want_rate[31:0])
        report("table rate", want.rate_bps, rows[i].want_rate[31:0]);
      if (rows[i].want_drop >= 0 && want.dropped !== rows[i].want_drop[0])
        report("table drop", {31'd0, want.dropped}, rows[i].want_drop);
    end
    // The table check above ran on the shadow state; rerun it against the block.
    meter_reset();
    foreach (rows[i])
      send_word(make_word(rows[i].cmd, rows[i].bytes, rows[i].proto, rows[i].now));

    // Fill the pending queue past its depth, then the window store past its depth.
    for (int i = 0; i < PEND_MAX + 2; i++)
      send_word(make_word(CMD_QUEUE, 32'd10, 1'b0, 32'd10000));
    send_word(make_word(CMD_SENT, 32'hFFFF_FFFF, 1'b0, 32'd10005));
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < PEND_MAX; j++)
        send_word(make_word(CMD_QUEUE, 32'd100, 1'b0, 32'd10010));
      send_word(make_word(CMD_SENT, 32'd1600, 1'b0, 32'd10020 + i));
    end
    send_word(make_word(CMD_UPDATE, 32'd0, 1'b0, 32'd10030));

    // Back pressure: the receiver holds off while words keep coming.
    hold_out = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_out = 1'b0;
      end
      for (int i = 0; i < 8; i++)
        send_word(make_word(CMD_NONE, $urandom, 1'b0, $urandom));
    join

    clock_ms = 32'hFFFF_0000;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_window(16'd0);
        1: set_window(16'hFFFF);
        2: set_window(16'd500);
        default: set_window(16'd3000);
      endcase
      quiet = (phase == 2);
      n = 7;
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(99);
        clock_ms += $urandom_range(pick < 5 ? 70000 : 400);
        if (pick < 40) begin
          send_word(make_word(CMD_QUEUE,
                              (pick < 3) ? $urandom : $urandom_range(5000),
                              ($urandom_range(3) == 0), clock_ms - $urandom_range(50)));
        end else if (pick < 75) begin
          send_word(make_word(CMD_SENT,
                              (pick < 43) ? $urandom : $urandom_range(6000),
                              $urandom_range(1), clock_ms));
        end else if (pick < 96) begin
          send_word(make_word(CMD_UPDATE, $urandom, $urandom_range(1),
                              (pick < 78) ? $urandom : clock_ms));
        end else begin
          send_word(make_word(CMD_NONE, $urandom, $urandom_range(1), $urandom));
        end
      end
      quiet = 1'b0;
    end

    in_valid <= 1'b0;
    fork
      begin
        while (expected_words.size() != 0) @(posedge clk);
        repeat (5000) @(posedge clk);
      end
      begin
        repeat (WATCHDOG_LIMIT) @(posedge clk);
        errors++;
      end
    join_any
    if (expected_words.size() != 0)
      errors++;
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
